// ===== rtl/fmtsp_pkg.sv =====
// Shared constants, widths and the result record of the format specifier parser.
package fmtsp_pkg;

    // Longest specifier that the length field counts to; the 8-bit field caps it at 255.
    localparam int MAX_SPEC_LEN = 255;
    localparam logic [7:0] LEN_CAP = (MAX_SPEC_LEN < 255) ? 8'(MAX_SPEC_LEN) : 8'd255;

    localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

    localparam int IN_W  = 40;  // ch(8) + star_arg(32)
    localparam int OUT_W = 88;  // 83 payload bits padded to whole bytes

    // Phase codes of the parse.
    localparam logic [2:0] PH_FLAGS  = 3'd0;
    localparam logic [2:0] PH_WDIG   = 3'd1;
    localparam logic [2:0] PH_WDONE  = 3'd2;
    localparam logic [2:0] PH_PSTART = 3'd3;
    localparam logic [2:0] PH_PDIG   = 3'd4;
    localparam logic [2:0] PH_PDONE  = 3'd5;

    // Characters of interest.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_X_LO    = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_U       = 8'h75;

    typedef struct packed {
        logic [7:0]  spec_length;
        logic        emit_space;
        logic [30:0] precision_value;
        logic        has_precision;
        logic [30:0] field_width;
        logic        left_justify;
        logic        zero_pad;
        logic        bad_type;
        logic [7:0]  type_char;
    } t_result;

    // Accumulate one decimal digit, saturating at VAL_MAX.
    function automatic logic [30:0] add_digit(input logic [31:0] acc, input logic [3:0] dig);
        logic [35:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, dig};
        add_digit = (v > {5'd0, VAL_MAX}) ? VAL_MAX : v[30:0];
    endfunction

endpackage

// ===== rtl/format_spec_parser.sv =====
// Format specifier parser: one specifier character per word in, one parse result out.
//
// Usage:
//   Slave channel (i_s_*) takes the characters of one conversion specifier, one
//   per word, starting with the character after the percent sign. A star word
//   also carries the integer argument it stands for. Digits, star, dot, minus
//   and space are absorbed; the first other character is the type and closes
//   the specifier.
//   Master channel (o_m_*) gives one result word per closing character: type,
//   bad-type flag, zero/minus flags, width, precision, space flag and length.
// Timing:
//   One word accepted per cycle, unless a closing word waits on a held result. A word
//   passes an input register and the parse step (compare plus a shift-add multiply by
//   ten) into the result register, where the result word is held until it is taken.
// Reset:
//   i_rst_n low clears both stages and rearms the parse at the flags phase.
// Stall:
//   While i_m_tready is low the result holds; absorbed characters still flow, and
//   the next closing character waits in the input register with o_s_tready low.
module format_spec_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [fmtsp_pkg::IN_W-1:0]    i_s_tdata,   // [7:0] ch, [39:8] star_arg
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] type_char, [8] bad_type, [9] zero_pad, [10] left_justify,
    // [41:11] field_width, [42] has_precision, [73:43] precision_value,
    // [74] emit_space, [82:75] spec_length, [87:83] zero
    output logic [fmtsp_pkg::OUT_W-1:0]   o_m_tdata
);
    import fmtsp_pkg::*;

    // Input stage.
    logic        r_in_valid;
    logic [7:0]  r_ch;
    logic [31:0] r_arg;

    // Parse state.
    logic [2:0]  r_phase,  n_phase;
    logic        r_zero,   n_zero;
    logic        r_minus,  n_minus;
    logic        r_space,  n_space;
    logic [30:0] r_width,  n_width;
    logic        r_dot,    n_dot;
    logic [31:0] r_prec,   n_prec;
    logic [7:0]  r_count,  n_count;

    // Result stage.
    logic        r_out_valid;
    t_result     r_res, n_res;

    logic        is_dig, skip, type_ok, out_free, step, in_take, hp;
    logic [2:0]  ph_eff;
    logic [8:0]  len_sum;
    logic [32:0] neg_mag;

    assign out_free   = !r_out_valid || i_m_tready;
    assign is_dig     = r_ch inside {[CH_ZERO:CH_NINE]};
    assign skip       = is_dig || (r_ch inside {CH_STAR, CH_DOT, CH_MINUS, CH_SPACE});
    // Absorbed characters never need the result register; a type does.
    assign step       = r_in_valid && (skip || out_free);
    assign o_s_tready = !r_in_valid || step;
    assign in_take    = i_s_tvalid && o_s_tready;

    assign type_ok = r_ch inside {CH_D, CH_I, CH_C, CH_S, CH_PERCENT, CH_X_LO, CH_X_UP,
                                  CH_P, CH_U};

    assign neg_mag = 33'h1_0000_0000 - {1'b0, r_arg};
    assign len_sum = {1'b0, r_count} + 9'd1;
    assign hp      = r_dot && (r_ch != CH_PERCENT) && !r_prec[31];

    always_comb begin
        // Leaving a digit run on a non-digit closes that field first.
        if (r_phase == PH_WDIG && !is_dig) begin
            ph_eff = PH_WDONE;
        end else if (r_phase == PH_PDIG && !is_dig) begin
            ph_eff = PH_PDONE;
        end else begin
            ph_eff = r_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_zero  = r_zero;
        n_minus = r_minus;
        n_space = r_space;
        n_width = r_width;
        n_dot   = r_dot;
        n_prec  = r_prec;
        n_count = r_count;
        n_res   = r_res;
        if (skip) begin
            if (r_count < LEN_CAP) begin
                n_count = r_count + 8'd1;
            end
            if (r_ch == CH_SPACE) begin
                n_space = 1'b1;
            end
            n_phase = ph_eff;
            case (ph_eff)
                PH_FLAGS: begin
                    if (r_ch == CH_ZERO) begin
                        n_zero = 1'b1;
                    end else if (r_ch == CH_MINUS) begin
                        n_minus = 1'b1;
                    end else if (r_ch == CH_STAR) begin
                        // Negative star width: left-justify with the magnitude.
                        if (r_arg[31]) begin
                            n_minus = 1'b1;
                            n_width = (neg_mag > {2'b00, VAL_MAX}) ? VAL_MAX : neg_mag[30:0];
                        end else begin
                            n_width = r_arg[30:0];
                        end
                        n_phase = PH_WDONE;
                    end else if (r_ch == CH_DOT) begin
                        n_dot   = 1'b1;
                        n_phase = PH_PSTART;
                    end else if (is_dig) begin
                        n_width = {27'd0, r_ch[3:0]};
                        n_phase = PH_WDIG;
                    end
                end
                PH_WDIG: begin
                    n_width = add_digit({1'b0, r_width}, r_ch[3:0]);
                end
                PH_WDONE: begin
                    if (r_ch == CH_DOT) begin
                        n_dot   = 1'b1;
                        n_phase = PH_PSTART;
                    end
                end
                PH_PSTART: begin
                    if (is_dig) begin
                        n_prec  = {28'd0, r_ch[3:0]};
                        n_phase = PH_PDIG;
                    end else if (r_ch == CH_STAR) begin
                        n_prec  = r_arg;
                        n_phase = PH_PDONE;
                    end else begin
                        n_phase = PH_PDONE;
                    end
                end
                PH_PDIG: begin
                    n_prec = {1'b0, add_digit(r_prec, r_ch[3:0])};
                end
                default: begin
                end
            endcase
        end else begin
            // Type character: build the result and rearm the parse.
            n_res             = '0;
            n_res.type_char   = r_ch;
            n_res.bad_type    = !type_ok;
            n_res.spec_length = (len_sum > {1'b0, LEN_CAP}) ? LEN_CAP : len_sum[7:0];
            if (type_ok) begin
                n_res.zero_pad        = r_zero && !r_minus;
                n_res.left_justify    = r_minus;
                n_res.field_width     = r_width;
                n_res.has_precision   = hp;
                n_res.precision_value = hp ? r_prec[30:0] : 31'd0;
                n_res.emit_space      = r_space;
            end
            n_phase = PH_FLAGS;
            n_zero  = 1'b0;
            n_minus = 1'b0;
            n_space = 1'b0;
            n_width = '0;
            n_dot   = 1'b0;
            n_prec  = '0;
            n_count = 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_FLAGS;
            r_zero      <= 1'b0;
            r_minus     <= 1'b0;
            r_space     <= 1'b0;
            r_width     <= '0;
            r_dot       <= 1'b0;
            r_prec      <= '0;
            r_count     <= 8'd1;
        end else begin
            // Hold the input word until the parse step takes it.
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_phase <= n_phase;
                r_zero  <= n_zero;
                r_minus <= n_minus;
                r_space <= n_space;
                r_width <= n_width;
                r_dot   <= n_dot;
                r_prec  <= n_prec;
                r_count <= n_count;
            end
            // Advance the result register on a type; drop it once taken.
            if (step && !skip) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch  <= i_s_tdata[7:0];
            r_arg <= i_s_tdata[39:8];
        end
        if (step && !skip) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_res};

`ifndef ASSERT_OFF
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !skip) |=> (r_phase == PH_FLAGS && r_count == 8'd1 && !r_dot))
        else $error("parse state not rearmed after type character");

    a_bad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.bad_type) |-> (r_res.field_width == 31'd0
            && !r_res.has_precision && !r_res.left_justify && !r_res.emit_space))
        else $error("bad type result carries nonzero fields");

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.spec_length >= 8'd2 && r_res.spec_length <= LEN_CAP))
        else $error("spec length out of range");

    a_zero_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.zero_pad) |-> !r_res.left_justify)
        else $error("zero pad with left justify");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_res)))
        else $error("stalled result lost or overwritten");
`endif

endmodule
